@@ sv/fdm_pkg.sv @@
// Shared types, codes and helper functions for the FAT32 directory entry matcher.
// No dependencies; the top level and the checker import this package.
package fdm_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_ENTRY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ACK      = 3'd0,
    ST_NOMATCH  = 3'd1,
    ST_LONGPART = 3'd2,
    ST_DELETED  = 3'd3,
    ST_MATCH    = 3'd4,
    ST_END      = 3'd5,
    ST_IGNORED  = 3'd6
  } status_e;

  localparam logic [7:0] BYTE_END     = 8'h00;
  localparam logic [7:0] BYTE_DELETED = 8'hE5;
  localparam logic [7:0] ATTR_LFN     = 8'h0F;
  localparam logic [7:0] LFN_LAST     = 8'h40;
  localparam logic [7:0] LFN_ORD_MASK = 8'h1F;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam int unsigned LFN_CHARS   = 13;

  localparam logic [4:0] LFN_OFFSET [13] = '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16,
                                             5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30};

  typedef struct packed {
    logic [11:0][7:0] ch;
    logic [3:0]       len;
  } short_name_t;

  function automatic logic [7:0] ent_byte(input logic [255:0] e, input int unsigned n);
    ent_byte = e[8*n +: 8];
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // 8.3 name: base up to first space, optional dot, extension up to first space
  function automatic short_name_t build_short(input logic [255:0] e);
    short_name_t sn;
    logic        stop;
    logic [3:0]  j;
    sn   = '0;
    j    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop && ent_byte(e, i) != CHAR_SPACE) begin
        sn.ch[j] = ent_byte(e, i);
        j        = j + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
    if (ent_byte(e, 8) != CHAR_SPACE) begin
      sn.ch[j] = CHAR_DOT;
      j        = j + 4'd1;
    end
    stop = 1'b0;
    for (int i = 8; i < 11; i++) begin
      if (!stop && ent_byte(e, i) != CHAR_SPACE) begin
        sn.ch[j] = ent_byte(e, i);
        j        = j + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
    sn.len = j;
    return sn;
  endfunction

  // Each character group stops at its first zero character
  function automatic logic [12:0] lfn_mask(input logic [255:0] e);
    logic [12:0] m;
    logic        alive;
    m     = '0;
    alive = 1'b1;
    for (int k = 0; k < 13; k++) begin
      if (k == 0 || k == 5 || k == 11) alive = 1'b1;
      if (ent_byte(e, int'(LFN_OFFSET[k])) == 8'h00) alive = 1'b0;
      m[k] = alive;
    end
    return m;
  endfunction

endpackage

@@ sv/fat32_directory_entry_matcher_unit.sv @@
// Top level of the FAT32 directory entry matcher: sequencer, entry latch, result register.
// Depends on fdm_pkg and fdm_name_ram.
//
//  channel | signals                                          | dir
//  in      | in_valid_i, in_stall_o, cmd_i .. entry_word3_i   | to block
//  out     | out_valid_o, out_stall_i, status_o .. attribute_o | from block
//
// Load, begin, end, deleted and ignored words finish in the accept cycle.
// A long name part steps through its 13 characters in S_LWR; when it is the last part,
// S_CLR first zeroes the store below the new length. A name compare reads each character
// from memory (S_RD), then compares it (S_CMP), as the RAM read port is registered.
// Reset clears control state; the name memories keep their contents.
// The input stalls while busy and while a result waits on a stalled output.
module fat32_directory_entry_matcher_unit #(
  parameter int NAME_CHARS = 255
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [7:0]        name_index_i,
  input  logic [7:0]        name_byte_i,
  input  logic [7:0]        name_length_i,
  input  logic [63:0]       entry_word0_i,
  input  logic [63:0]       entry_word1_i,
  input  logic [63:0]       entry_word2_i,
  input  logic [63:0]       entry_word3_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [31:0]       first_cluster_o,
  output logic [31:0]       file_size_o,
  output logic [7:0]        attribute_o
);
  import fdm_pkg::*;

  localparam int AW = $clog2(NAME_CHARS);
  localparam int LW = $clog2(NAME_CHARS + 1);
  localparam logic [LW-1:0] MAX_LEN = LW'(NAME_CHARS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CLR  = 5'b00010,
    S_LWR  = 5'b00100,
    S_RD   = 5'b01000,
    S_CMP  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic        fin_q, fin_d;
  logic [LW-1:0] tl_q, tl_d, lnl_q, lnl_d, i_q, i_d;
  logic [3:0]  k_q, k_d;
  logic [255:0] e_q, e_d;
  short_name_t sn_q, sn_d;
  logic [12:0] mask_q, mask_d;
  logic        long_q, long_d;
  logic        ov_q, ov_d;
  status_e     st_q, st_d;
  logic [31:0] cl_q, cl_d, sz_q, sz_d;
  logic [7:0]  at_q, at_d;

  logic [255:0] entry;
  logic         accept;
  logic [7:0]   e0, e11;
  logic [8:0]   ord13;
  logic signed [9:0] pos;
  logic         t_we, l_we;
  logic [AW-1:0] l_waddr;
  logic [7:0]   l_wdata, t_rd, l_rd, a_ch;
  logic [LW-1:0] na;
  logic         a_end, b_end;

  assign entry  = {entry_word3_i, entry_word2_i, entry_word1_i, entry_word0_i};
  assign in_stall_o = (state_q != S_IDLE) || (ov_q && out_stall_i);
  assign accept = in_valid_i && !in_stall_o;
  assign e0     = ent_byte(entry, 0);
  assign e11    = ent_byte(entry, 11);
  assign ord13  = 9'(e0 & LFN_ORD_MASK) * 9'd13;
  assign pos    = 10'(signed'({1'b0, 9'(e_q[4:0]) * 9'd13})) - 10'sd13
                + 10'(signed'({1'b0, k_q}));

  assign t_we = accept && cmd_e'(cmd_i) == CMD_LOAD && name_index_i < 8'(NAME_CHARS);

  fdm_name_ram #(.DEPTH(NAME_CHARS), .AW(AW)) u_target (
    .clk_i, .we_i(t_we), .waddr_i(name_index_i[AW-1:0]), .wdata_i(name_byte_i),
    .raddr_i(i_q[AW-1:0]), .rdata_o(t_rd)
  );

  fdm_name_ram #(.DEPTH(NAME_CHARS), .AW(AW)) u_long (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(i_q[AW-1:0]), .rdata_o(l_rd)
  );

  assign a_ch  = long_q ? l_rd : sn_q.ch[i_q[3:0]];
  assign na    = long_q ? lnl_q : LW'(sn_q.len);
  assign a_end = (i_q >= na) || (a_ch == 8'h00);
  assign b_end = (i_q >= tl_q) || (t_rd == 8'h00);

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    tl_d    = tl_q;
    lnl_d   = lnl_q;
    i_d     = i_q;
    k_d     = k_q;
    e_d     = e_q;
    sn_d    = sn_q;
    mask_d  = mask_q;
    long_d  = long_q;
    ov_d    = ov_q && out_stall_i;
    st_d    = st_q;
    cl_d    = cl_q;
    sz_d    = sz_q;
    at_d    = at_q;
    l_we    = 1'b0;
    l_waddr = i_q[AW-1:0];
    l_wdata = 8'h00;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ov_d = 1'b1;
          st_d = ST_IGNORED;
          cl_d = '0;
          sz_d = '0;
          at_d = '0;
          e_d  = entry;
          case (cmd_e'(cmd_i))
            CMD_LOAD: begin
              if (name_index_i < 8'(NAME_CHARS)) st_d = ST_ACK;
            end
            CMD_BEGIN: begin
              tl_d  = (name_length_i > 8'(NAME_CHARS)) ? MAX_LEN : LW'(name_length_i);
              lnl_d = '0;
              fin_d = 1'b0;
              st_d  = ST_ACK;
            end
            CMD_ENTRY: begin
              if (!fin_q) begin
                if (e0 == BYTE_END) begin
                  fin_d = 1'b1;
                  st_d  = ST_END;
                end else if (e0 == BYTE_DELETED) begin
                  lnl_d = '0;
                  st_d  = ST_DELETED;
                end else if (e11 == ATTR_LFN) begin
                  ov_d   = 1'b0;
                  mask_d = lfn_mask(entry);
                  k_d    = '0;
                  i_d    = '0;
                  state_d = S_LWR;
                  if ((e0 & LFN_LAST) != 8'h00) begin
                    lnl_d = (ord13 > 9'(NAME_CHARS)) ? MAX_LEN : LW'(ord13);
                    if (ord13 != 9'd0) state_d = S_CLR;
                  end
                end else begin
                  ov_d    = 1'b0;
                  sn_d    = build_short(entry);
                  long_d  = (lnl_q != '0);
                  i_d     = '0;
                  state_d = S_RD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        // zero the store below the new long name length
        l_we = 1'b1;
        i_d  = i_q + 1'b1;
        if (i_q + 1'b1 == lnl_q) state_d = S_LWR;
      end
      S_LWR: begin
        l_waddr = pos[AW-1:0];
        l_wdata = ent_byte(e_q, int'(LFN_OFFSET[k_q]));
        l_we    = mask_q[k_q] && pos >= 10'sd0 && pos < 10'(NAME_CHARS);
        k_d     = k_q + 4'd1;
        if (k_q == 4'(LFN_CHARS - 1)) begin
          ov_d    = 1'b1;
          st_d    = ST_LONGPART;
          state_d = S_IDLE;
        end
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        if (a_end && b_end) begin
          ov_d    = 1'b1;
          st_d    = ST_MATCH;
          cl_d    = {ent_byte(e_q, 21), ent_byte(e_q, 20), ent_byte(e_q, 27), ent_byte(e_q, 26)};
          sz_d    = {ent_byte(e_q, 31), ent_byte(e_q, 30), ent_byte(e_q, 29), ent_byte(e_q, 28)};
          at_d    = ent_byte(e_q, 11);
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end else if (a_end || b_end || fold(a_ch) != fold(t_rd)) begin
          ov_d    = 1'b1;
          st_d    = ST_NOMATCH;
          lnl_d   = '0;
          state_d = S_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
      tl_q    <= '0;
      lnl_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      tl_q    <= tl_d;
      lnl_q   <= lnl_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    k_q    <= k_d;
    e_q    <= e_d;
    sn_q   <= sn_d;
    mask_q <= mask_d;
    long_q <= long_d;
    st_q   <= st_d;
    cl_q   <= cl_d;
    sz_q   <= sz_d;
    at_q   <= at_d;
  end

  assign out_valid_o     = ov_q;
  assign status_o        = st_q;
  assign first_cluster_o = cl_q;
  assign file_size_o     = sz_q;
  assign attribute_o     = at_q;
endmodule

@@ sv/fdm_name_ram.sv @@
// Byte-wide name memory: one write port, one registered read port.
// Depends on nothing; used for the target name and the long name store.
module fdm_name_ram #(
  parameter int DEPTH = 255,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ sv/fdm_checker.sv @@
// Port-level checks for the FAT32 directory entry matcher, bound to the top level.
// Depends on fdm_pkg.
module fdm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [31:0] first_cluster_o,
  input logic [31:0] file_size_o,
  input logic [7:0]  attribute_o
);
  import fdm_pkg::*;

  a_hold_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o) else $error("input taken over stalled word");

  a_out_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("stalled word dropped");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_MATCH |->
      first_cluster_o == '0 && file_size_o == '0 && attribute_o == '0)
    else $error("fields set without match");

  a_none_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_NONE |=> out_valid_o && status_o == ST_IGNORED)
    else $error("no-command word not ignored");
endmodule

bind fat32_directory_entry_matcher_unit fdm_checker u_fdm_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .out_valid_o, .out_stall_i,
  .status_o, .first_cluster_o, .file_size_o, .attribute_o
);
